FILE: rtl/twl_pkg.sv
// Shared constants, types and width helpers for the trilinear window/level gray mapper.
package twl_pkg;

  localparam int SAMPLE_BITS_DEF   = 16;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int WIN_W     = 16;
  localparam int DIV_W     = WIN_W + 1;
  localparam int GRAY_W    = 8;
  localparam int CFG_IDX_W = 2;

  localparam int QUO_BITS        = 8;
  localparam int STEPS_PER_STAGE = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CENTER = 2'd1;

  localparam logic [WIN_W-1:0] WIDTH_RESET  = 16'd256;
  localparam logic [WIN_W-1:0] CENTER_RESET = 16'd0;

  localparam logic [GRAY_W-1:0] GRAY_MAX = 8'hFF;

  typedef struct packed {
    logic [WIN_W-1:0]        width;   // zero already replaced by one
    logic signed [WIN_W-1:0] center;
  } twl_cfg_t;

  // Signed width of q + width - 2*center - 2^S.
  function automatic int acc_bits(int sample_bits);
    int m;
    begin
      m = (sample_bits + 1 > WIN_W + 1) ? sample_bits + 1 : WIN_W + 1;
      return m + 3;
    end
  endfunction

  // Width of the nonnegative numerator handed to the divider.
  function automatic int rem_bits(int sample_bits);
    begin
      return acc_bits(sample_bits) + 8;
    end
  endfunction

endpackage

FILE: rtl/trilinear_window_level_gray.sv
// Top level: config registers, stream ports and the interpolate / map / divide pipeline.
// Pipeline: 4 interpolation stages, 2 mapping stages, 4 divider stages at two quotient
// bits each, 1 output register.
// Throughput: one point per cycle; each stage holds its request under backpressure.
// Reset (rst_n low, synchronous): all stage valid bits clear, window_width returns
// to 256 and window_center to 0. Config writes are accepted on every cycle.
module trilinear_window_level_gray #(
  parameter int SAMPLE_BITS   = twl_pkg::SAMPLE_BITS_DEF,
  parameter int FRACTION_BITS = twl_pkg::FRACTION_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // corner_000, corner_100, corner_010, corner_110, corner_001, corner_101,
  // corner_011, corner_111, frac_x, frac_y, frac_z, zero fill
  input  logic [((8*SAMPLE_BITS+3*FRACTION_BITS+7)/8)*8-1:0] in_tdata,
  input  logic                                 in_tuser,   // inside_volume
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  output logic [twl_pkg::GRAY_W-1:0]           out_tdata,  // gray_level
  output logic                                 out_tuser,  // was_outside
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [twl_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [twl_pkg::WIN_W-1:0]            cfg_data
);

  localparam int S     = SAMPLE_BITS;
  localparam int F     = FRACTION_BITS;
  localparam int REM_W = twl_pkg::rem_bits(SAMPLE_BITS);

  // ---- configuration registers
  logic [twl_pkg::WIN_W-1:0] width_r, center_r;
  twl_pkg::twl_cfg_t         cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= twl_pkg::WIDTH_RESET;
      center_r <= twl_pkg::CENTER_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        twl_pkg::CFG_IDX_WIDTH:  width_r  <= cfg_data;
        twl_pkg::CFG_IDX_CENTER: center_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // a zero width acts as one
  assign cfg.width  = (width_r == '0) ? {{(twl_pkg::WIN_W-1){1'b0}}, 1'b1} : width_r;
  assign cfg.center = $signed(center_r);

  // ---- unpack request
  logic [7:0][S-1:0] corners;
  logic [F-1:0]      frac_x, frac_y, frac_z;

  assign corners = in_tdata[8*S-1:0];
  assign frac_x  = in_tdata[8*S +: F];
  assign frac_y  = in_tdata[8*S+F +: F];
  assign frac_z  = in_tdata[8*S+2*F +: F];

  // ---- pipeline
  logic             l_valid, l_ready;
  logic [S:0]       l_q;
  logic [3*F-1:0]   l_r;
  logic             l_out;
  logic             m_valid, m_ready;
  logic [REM_W-1:0] m_num;
  logic             m_neg, m_out;

  twl_lerp #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_lerp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .corners     (corners),
    .frac_x      (frac_x),
    .frac_y      (frac_y),
    .frac_z      (frac_z),
    .inside_vol  (in_tuser),
    .out_valid   (l_valid),
    .out_ready   (l_ready),
    .q_out       (l_q),
    .r_out       (l_r),
    .outside_out (l_out)
  );

  twl_map #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_map (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .in_valid    (l_valid),
    .in_ready    (l_ready),
    .q_in        (l_q),
    .r_in        (l_r),
    .outside_in  (l_out),
    .out_valid   (m_valid),
    .out_ready   (m_ready),
    .num_out     (m_num),
    .neg_out     (m_neg),
    .outside_out (m_out)
  );

  twl_div #(
    .REM_W (REM_W)
  ) u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .in_valid    (m_valid),
    .in_ready    (m_ready),
    .num_in      (m_num),
    .neg_in      (m_neg),
    .outside_in  (m_out),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .gray_out    (out_tdata),
    .outside_out (out_tuser)
  );

endmodule

FILE: rtl/twl_lerp.sv
// Four-stage trilinear blend of eight biased corner samples, producing quotient and remainder bits.
module twl_lerp #(
  parameter int SAMPLE_BITS   = twl_pkg::SAMPLE_BITS_DEF,
  parameter int FRACTION_BITS = twl_pkg::FRACTION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0][SAMPLE_BITS-1:0]         corners,
  input  logic [FRACTION_BITS-1:0]            frac_x,
  input  logic [FRACTION_BITS-1:0]            frac_y,
  input  logic [FRACTION_BITS-1:0]            frac_z,
  input  logic                                inside_vol,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [SAMPLE_BITS:0]                q_out,
  output logic [3*FRACTION_BITS-1:0]          r_out,
  output logic                                outside_out
);

  localparam int S  = SAMPLE_BITS;
  localparam int F  = FRACTION_BITS;
  localparam int XW = S + F;
  localparam int YW = S + 2 * F;
  localparam int SX = S + 3 * F + 2;

  logic en1, en2, en3, en4;
  logic v1_r, v2_r, v3_r, v4_r;

  assign en4      = !v4_r || out_ready;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  // ---- stage 1: blend along x
  logic [S-1:0]        u [8];
  logic [F-1:0]        fx, fy_in, fz_in;
  logic signed [S:0]   dx [4];
  logic signed [XW+1:0] px [4];
  logic [XW-1:0]       x_nxt [4];
  logic [XW-1:0]       x_r [4];
  logic [F-1:0]        fy1_r, fz1_r;
  logic                out1_r;

  always_comb begin
    fx    = inside_vol ? frac_x : '0;
    fy_in = inside_vol ? frac_y : '0;
    fz_in = inside_vol ? frac_z : '0;
    for (int i = 0; i < 8; i++) begin
      // bias to unsigned; an outside point reads as zero everywhere
      u[i] = inside_vol ? {~corners[i][S-1], corners[i][S-2:0]} : {1'b1, {(S-1){1'b0}}};
    end
    for (int k = 0; k < 4; k++) begin
      dx[k]    = $signed({1'b0, u[2*k+1]}) - $signed({1'b0, u[2*k]});
      px[k]    = dx[k] * $signed({1'b0, fx});
      x_nxt[k] = XW'($signed({2'b00, u[2*k], {F{1'b0}}}) + px[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      for (int k = 0; k < 4; k++) x_r[k] <= x_nxt[k];
      fy1_r  <= fy_in;
      fz1_r  <= fz_in;
      out1_r <= !inside_vol;
    end
  end

  // ---- stage 2: blend along y
  logic signed [XW:0]     dy [2];
  logic signed [XW+F+1:0] py [2];
  logic [YW-1:0]          y_nxt [2];
  logic [YW-1:0]          y_r [2];
  logic [F-1:0]           fz2_r;
  logic                   out2_r;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      dy[k]    = $signed({1'b0, x_r[2*k+1]}) - $signed({1'b0, x_r[2*k]});
      py[k]    = dy[k] * $signed({1'b0, fy1_r});
      y_nxt[k] = YW'($signed({2'b00, x_r[2*k], {F{1'b0}}}) + py[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      y_r[0] <= y_nxt[0];
      y_r[1] <= y_nxt[1];
      fz2_r  <= fz1_r;
      out2_r <= out1_r;
    end
  end

  // ---- stage 3: z difference times fraction, split in two partial products
  logic signed [YW:0]      dz;
  logic [XW-1:0]           dz_lo;
  logic signed [F:0]       dz_hi;
  logic [XW+F-1:0]         plo_nxt, plo_r;
  logic signed [2*F+1:0]   phi_nxt, phi_r;
  logic [YW-1:0]           y0_r;
  logic                    out3_r;

  always_comb begin
    dz      = $signed({1'b0, y_r[1]}) - $signed({1'b0, y_r[0]});
    dz_lo   = dz[XW-1:0];
    dz_hi   = dz[YW:XW];
    plo_nxt = dz_lo * fz2_r;
    phi_nxt = dz_hi * $signed({1'b0, fz2_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      plo_r  <= plo_nxt;
      phi_r  <= phi_nxt;
      y0_r   <= y_r[0];
      out3_r <= out2_r;
    end
  end

  // ---- stage 4: sum partial products, split 2*s into integer and fraction
  logic signed [SX-1:0]    s_sum;
  logic [S+3*F-1:0]        s_val;
  logic [S:0]              q_nxt, q_r;
  logic [3*F-1:0]          r_nxt, r_r;
  logic                    out4_r;

  always_comb begin
    s_sum = $signed({2'b00, y0_r, {F{1'b0}}})
          + $signed({phi_r, {XW{1'b0}}})
          + $signed({{(F+2){1'b0}}, plo_r});
    s_val = s_sum[S+3*F-1:0];
    q_nxt = s_val[S+3*F-1:3*F-1];
    r_nxt = {s_val[3*F-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en4) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      q_r    <= q_nxt;
      r_r    <= r_nxt;
      out4_r <= out3_r;
    end
  end

  assign out_valid   = v4_r;
  assign q_out       = q_r;
  assign r_out       = r_r;
  assign outside_out = out4_r;

endmodule

FILE: rtl/twl_map.sv
// Two-stage window/level numerator: 255*(q + width - 2*center - 2^S) + fraction term.
module twl_map #(
  parameter int SAMPLE_BITS   = twl_pkg::SAMPLE_BITS_DEF,
  parameter int FRACTION_BITS = twl_pkg::FRACTION_BITS_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  twl_pkg::twl_cfg_t                                 cfg,
  input  logic                                              in_valid,
  output logic                                              in_ready,
  input  logic [SAMPLE_BITS:0]                              q_in,
  input  logic [3*FRACTION_BITS-1:0]                        r_in,
  input  logic                                              outside_in,
  output logic                                              out_valid,
  input  logic                                              out_ready,
  output logic [twl_pkg::rem_bits(SAMPLE_BITS)-1:0]         num_out,
  output logic                                              neg_out,
  output logic                                              outside_out
);

  localparam int S  = SAMPLE_BITS;
  localparam int F  = FRACTION_BITS;
  localparam int AW = twl_pkg::acc_bits(SAMPLE_BITS);
  localparam int NW = AW + 9;
  localparam int WW = twl_pkg::WIN_W;

  logic en5, en6;
  logic v5_r, v6_r;

  assign en6      = !v6_r || out_ready;
  assign en5      = !v5_r || en6;
  assign in_ready = en5;

  // ---- stage 5: 255*r >> 3F and the level offset
  logic [3*F+7:0]        rr;
  logic [7:0]            p_nxt, p_r;
  logic signed [AW-1:0]  bias_c;
  logic signed [AW-1:0]  a_nxt, a_r;
  logic                  out5_r;

  assign bias_c = {{(AW-S-1){1'b0}}, 1'b1, {S{1'b0}}};

  always_comb begin
    rr    = {r_in, 8'b0} - {8'b0, r_in};
    p_nxt = rr[3*F+7:3*F];
    a_nxt = $signed({{(AW-S-1){1'b0}}, q_in})
          + $signed({{(AW-WW){1'b0}}, cfg.width})
          - ($signed({{(AW-WW){cfg.center[WW-1]}}, cfg.center}) <<< 1)
          - bias_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en5) begin
      v5_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      p_r    <= p_nxt;
      a_r    <= a_nxt;
      out5_r <= outside_in;
    end
  end

  // ---- stage 6: numerator and its sign
  logic signed [NW-1:0] a_ext;
  logic signed [NW-1:0] num_nxt;
  logic [NW-2:0]        num_r;
  logic                 neg_r, out6_r;

  always_comb begin
    a_ext   = {{9{a_r[AW-1]}}, a_r};
    num_nxt = (a_ext <<< 8) - a_ext + $signed({{(NW-8){1'b0}}, p_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en6) begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      num_r  <= num_nxt[NW-2:0];
      neg_r  <= num_nxt[NW-1];
      out6_r <= out5_r;
    end
  end

  assign out_valid   = v6_r;
  assign num_out     = num_r;
  assign neg_out     = neg_r;
  assign outside_out = out6_r;

endmodule

FILE: rtl/twl_div.sv
// Pipelined restoring divide by 2*width, two quotient bits per stage, with clamp output stage.
module twl_div #(
  parameter int REM_W = twl_pkg::rem_bits(twl_pkg::SAMPLE_BITS_DEF)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  twl_pkg::twl_cfg_t           cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [REM_W-1:0]            num_in,
  input  logic                        neg_in,
  input  logic                        outside_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [twl_pkg::GRAY_W-1:0]  gray_out,
  output logic                        outside_out
);

  localparam int QB  = twl_pkg::QUO_BITS;
  localparam int SPS = twl_pkg::STEPS_PER_STAGE;
  localparam int NST = QB / SPS;
  localparam int DW  = twl_pkg::DIV_W;

  logic [DW-1:0]    divisor;
  logic [REM_W-1:0] sat_lim;

  assign divisor = {cfg.width, 1'b0};
  assign sat_lim = {{(REM_W-DW-QB){1'b0}}, divisor, {QB{1'b0}}};

  logic [NST:0]     en;
  logic [NST-1:0]   v_r, sat_r, neg_r, out_r;
  logic [REM_W-1:0] rem_r [NST];
  logic [QB-1:0]    quo_r [NST];
  logic             ov_r;

  assign in_ready = en[0];

  genvar k;
  generate
    for (k = 0; k < NST; k++) begin : g_stage
      logic [REM_W-1:0] rem_in, rem_nxt, dsh;
      logic [QB-1:0]    quo_in, quo_nxt;
      logic             v_in, sat_in, neg_in_k, out_in;

      assign en[k] = !v_r[k] || en[k+1];

      if (k == 0) begin : g_first
        assign rem_in   = num_in;
        assign quo_in   = '0;
        assign v_in     = in_valid;
        assign sat_in   = num_in >= sat_lim;
        assign neg_in_k = neg_in;
        assign out_in   = outside_in;
      end else begin : g_next
        assign rem_in   = rem_r[k-1];
        assign quo_in   = quo_r[k-1];
        assign v_in     = v_r[k-1];
        assign sat_in   = sat_r[k-1];
        assign neg_in_k = neg_r[k-1];
        assign out_in   = out_r[k-1];
      end

      always_comb begin
        rem_nxt = rem_in;
        quo_nxt = quo_in;
        dsh     = '0;
        for (int j = 0; j < SPS; j++) begin
          dsh = {{(REM_W-DW){1'b0}}, divisor} << (QB - 1 - k * SPS - j);
          if (rem_nxt >= dsh) begin
            rem_nxt                      = rem_nxt - dsh;
            quo_nxt[QB-1-k*SPS-j]        = 1'b1;
          end
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k] <= 1'b0;
        end else if (en[k]) begin
          v_r[k] <= v_in;
        end
      end

      always_ff @(posedge clk) begin
        if (en[k]) begin
          rem_r[k] <= rem_nxt;
          quo_r[k] <= quo_nxt;
          sat_r[k] <= sat_in;
          neg_r[k] <= neg_in_k;
          out_r[k] <= out_in;
        end
      end
    end
  endgenerate

  // ---- output register: clamp to 0..255
  logic [twl_pkg::GRAY_W-1:0] gray_nxt, gray_r;
  logic                       outside_r;

  assign en[NST] = !ov_r || out_ready;

  always_comb begin
    if (neg_r[NST-1]) begin
      gray_nxt = '0;
    end else if (sat_r[NST-1]) begin
      gray_nxt = twl_pkg::GRAY_MAX;
    end else begin
      gray_nxt = quo_r[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en[NST]) begin
      ov_r <= v_r[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[NST]) begin
      gray_r    <= gray_nxt;
      outside_r <= out_r[NST-1];
    end
  end

  assign out_valid   = ov_r;
  assign gray_out    = gray_r;
  assign outside_out = outside_r;

endmodule

FILE: dv/tb_top.sv
// Self-checking stream testbench for the trilinear window/level gray mapper.
`timescale 1ns / 100ps

module tb_top;

  localparam int PIPE_LATENCY = 11;
  localparam int STALL_LIMIT  = 2000;
  localparam int PHASES       = 13;
  localparam int PHASE_POINTS = 100;

  // indexes that the block decodes to nothing
  localparam logic [twl_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_2 = 2'd2;
  localparam logic [twl_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_3 = 2'd3;

  // corner[i] follows the bus order 000,100,010,110,001,101,011,111
  typedef struct packed {
    logic [15:0]       frac_z;
    logic [15:0]       frac_y;
    logic [15:0]       frac_x;
    logic [7:0][15:0]  corner;
  } cell_t;

  typedef struct packed {
    logic [twl_pkg::GRAY_W-1:0] gray;
    logic                       outside;
  } shade_t;

  logic clk = 1'b0;
  logic rst_n;
  logic [175:0]                   in_tdata;
  logic                           in_tuser;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [twl_pkg::GRAY_W-1:0]     out_tdata;
  logic                           out_tuser;
  logic                           out_tvalid;
  logic                           out_tready;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [twl_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [twl_pkg::WIN_W-1:0]      cfg_data;

  // local copy of the window registers
  logic [twl_pkg::WIN_W-1:0]        win_width;
  logic signed [twl_pkg::WIN_W-1:0] win_center;

  shade_t shade_due[$];
  int     mismatch_count = 0;
  int     idle_cycles = 0;
  bit     src_lazy = 1'b1;
  bit     sink_lazy = 1'b1;

  trilinear_window_level_gray dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // a*(1-f) + b*f with f in Q0.16, kept exact at 128 bits
  function automatic logic [127:0] blend(logic [127:0] a, logic [127:0] b, logic [15:0] f);
    logic [127:0] fw;
    logic [127:0] cw;
    fw = {112'd0, f};
    cw = 128'h1_0000 - fw;
    return a * cw + b * fw;
  endfunction

  function automatic shade_t window_gray(cell_t pt, logic in_vol);
    logic [127:0] u[8];
    logic [127:0] x[4];
    logic [127:0] y0, y1, s2, frac_part;
    logic [15:0]  fx, fy, fz;
    longint       q, p, wv, lv, num, t;
    shade_t       res;
    fx = in_vol ? pt.frac_x : 16'd0;
    fy = in_vol ? pt.frac_y : 16'd0;
    fz = in_vol ? pt.frac_z : 16'd0;
    // bias samples to unsigned; outside points sit at the bias, i.e. value 0
    for (int i = 0; i < 8; i++) begin
      u[i] = {112'd0, in_vol ? (pt.corner[i] ^ 16'h8000) : 16'h8000};
    end
    for (int j = 0; j < 4; j++) begin
      x[j] = blend(u[2*j], u[2*j+1], fx);
    end
    y0 = blend(x[0], x[1], fy);
    y1 = blend(x[2], x[3], fy);
    s2 = blend(y0, y1, fz) << 1;
    q = longint'(s2 >> 48);
    frac_part = {80'd0, s2[47:0]} * 128'd255;
    p = longint'(frac_part >> 48);
    wv = (win_width == 0) ? 64'sd1 : longint'(win_width);
    lv = longint'(win_center);
    num = 255 * (q + wv - 2 * lv - 65536) + p;
    if (num < 0) begin
      res.gray = '0;
    end else begin
      t = num / (2 * wv);
      res.gray = (t > 255) ? twl_pkg::GRAY_MAX : t[7:0];
    end
    res.outside = ~in_vol;
    return res;
  endfunction

  function automatic logic [15:0] sat16(int v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic logic [15:0] rand_frac();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic cell_t random_cell();
    cell_t c;
    for (int i = 0; i < 8; i++) c.corner[i] = 16'($urandom);
    c.frac_x = rand_frac();
    c.frac_y = rand_frac();
    c.frac_z = rand_frac();
    return c;
  endfunction

  // corners clustered around the current window so the gray ramp gets exercised
  function automatic cell_t windowed_cell();
    cell_t c;
    int    span, base, spread;
    span = (win_width == 0) ? 1 : int'(win_width);
    base = int'(win_center) + int'($urandom_range(0, 2 * span)) - span;
    case ($urandom_range(0, 2))
      0: spread = 2;
      1: spread = 200;
      default: spread = 6000;
    endcase
    for (int i = 0; i < 8; i++) begin
      c.corner[i] = sat16(base + int'($urandom_range(0, 2 * spread)) - spread);
    end
    c.frac_x = rand_frac();
    c.frac_y = rand_frac();
    c.frac_z = rand_frac();
    return c;
  endfunction

  task automatic report(string what, int got, int want);
    mismatch_count++;
    $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
  endtask

  task automatic send_point(cell_t pt, logic in_vol);
    int gap;
    gap = src_lazy ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pt;
    in_tuser  <= in_vol;
    do @(posedge clk); while (!in_tready);
    shade_due.push_back(window_gray(pt, in_vol));
  endtask

  // hold the input quiet until every request in flight has come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (shade_due.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(logic [twl_pkg::CFG_IDX_W-1:0] idx,
                           logic [twl_pkg::WIN_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      twl_pkg::CFG_IDX_WIDTH:  win_width = value;
      twl_pkg::CFG_IDX_CENTER: win_center = value;
      default: ;
    endcase
    // hold valid low between writes
    @(posedge clk);
  endtask

  task automatic set_window(logic [twl_pkg::WIN_W-1:0] width,
                            logic [twl_pkg::WIN_W-1:0] center);
    wait_drained();
    write_reg(twl_pkg::CFG_IDX_WIDTH, width);
    write_reg(twl_pkg::CFG_IDX_CENTER, center);
  endtask

  task automatic flat_point(logic [15:0] level);
    cell_t c;
    c.corner = {8{level}};
    c.frac_x = 16'($urandom);
    c.frac_y = 16'($urandom);
    c.frac_z = 16'($urandom);
    send_point(c, 1'b1);
  endtask

  task automatic test_default_window();
    flat_point(16'h0000);
    flat_point(16'h8000);
    flat_point(16'h7FFF);
  endtask

  task automatic test_corner_blend();
    cell_t c;
    c.corner = {4{16'h7FFF, 16'h8000}};
    c.frac_x = 16'h0000; c.frac_y = 16'h0000; c.frac_z = 16'h0000;
    send_point(c, 1'b1);
    c.frac_x = 16'hFFFF; c.frac_y = 16'hFFFF; c.frac_z = 16'hFFFF;
    send_point(c, 1'b1);
    c.frac_x = 16'h8000; c.frac_y = 16'h8000; c.frac_z = 16'h8000;
    send_point(c, 1'b1);
    c.corner = {16'h7FFF, {7{16'h8000}}};
    c.frac_x = 16'hFFFF; c.frac_y = 16'hFFFF; c.frac_z = 16'hFFFF;
    send_point(c, 1'b1);
    c.corner = {{7{16'h7FFF}}, 16'h8000};
    c.frac_x = 16'h0000; c.frac_y = 16'h0000; c.frac_z = 16'h0000;
    send_point(c, 1'b1);
    c.corner = {16'h0001, 16'hFFFF, 16'h0100, 16'hFF00, 16'h1234, 16'hEDCB, 16'h7FFF, 16'h8000};
    c.frac_x = 16'h0001; c.frac_y = 16'hAAAA; c.frac_z = 16'h5555;
    send_point(c, 1'b1);
  endtask

  // corner and fraction content must be ignored for points outside the volume
  task automatic test_outside_points();
    cell_t c;
    c = '1;
    send_point(c, 1'b0);
    send_point(random_cell(), 1'b0);
    send_point(random_cell(), 1'b0);
  endtask

  task automatic test_window_registers();
    // zero width behaves as width one
    set_window(16'd0, 16'd0);
    flat_point(16'h0000);
    flat_point(16'hFFFF);
    set_window(16'd1, 16'h7FFF);
    flat_point(16'h7FFF);
    flat_point(16'h7FFE);
    set_window(16'hFFFF, 16'h8000);
    flat_point(16'h8000);
    flat_point(16'h7FFF);
    flat_point(16'h0000);
    // writes to undecoded indexes must leave the window alone
    wait_drained();
    write_reg(CFG_IDX_SPARE_2, 16'($urandom));
    write_reg(CFG_IDX_SPARE_3, 16'($urandom));
    flat_point(16'h4000);
  endtask

  task automatic random_point();
    int kind;
    kind = $urandom_range(0, 19);
    if (kind < 14) send_point(windowed_cell(), 1'b1);
    else if (kind < 17) send_point(random_cell(), 1'b1);
    else send_point(random_cell(), 1'b0);
  endtask

  task automatic test_random_points();
    logic [twl_pkg::WIN_W-1:0] width, center;
    for (int ph = 0; ph < PHASES; ph++) begin
      case ($urandom_range(0, 9))
        0: width = 16'd0;
        1: width = 16'hFFFF;
        2, 3, 4: width = 16'($urandom_range(1, 16));
        5, 6, 7: width = 16'($urandom_range(17, 4096));
        default: width = 16'($urandom);
      endcase
      case ($urandom_range(0, 9))
        0: center = 16'h8000;
        1: center = 16'h7FFF;
        default: center = 16'($urandom);
      endcase
      set_window(width, center);
      if ($urandom_range(0, 3) == 0) begin
        write_reg(CFG_IDX_SPARE_2 | 2'($urandom_range(0, 1)), 16'($urandom));
      end
      src_lazy  = ($urandom_range(0, 3) != 0);
      sink_lazy = ($urandom_range(0, 3) != 0);
      repeat (PHASE_POINTS) random_point();
    end
    src_lazy  = 1'b1;
    sink_lazy = 1'b1;
  endtask

  task automatic test_pause_and_resume();
    repeat (20) random_point();
    wait_drained();
    repeat (20) random_point();
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (shade_due.size() == 0) begin
        report("unexpected result, gray", out_tdata, -1);
      end else begin
        if (out_tdata !== shade_due[0].gray) report("gray_level", out_tdata, shade_due[0].gray);
        if (out_tuser !== shade_due[0].outside)
          report("was_outside", out_tuser, shade_due[0].outside);
        void'(shade_due.pop_front());
      end
    end
  end

  // result side backpressure
  initial begin
    int stall;
    out_tready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = sink_lazy ? $urandom_range(0, 4) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
    end
  end

  // abort when no request moves on any channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= twl_pkg::CFG_IDX_WIDTH;
    cfg_data   <= '0;
    win_width  = twl_pkg::WIDTH_RESET;
    win_center = twl_pkg::CENTER_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_window();
    test_corner_blend();
    test_outside_points();
    test_window_registers();
    test_random_points();
    test_pause_and_resume();

    wait_drained();
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
